[sv/swbd_pkg.sv]
`default_nettype none

package swbd_pkg;

    // Widths of the transaction fields and the configuration port.
    localparam int LEVEL_W  = 16;
    localparam int DUR_W    = 16;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 3;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_SHORT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LONG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_HOLD   = 3'd4;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_START_HIGH = 10'd15;
    localparam logic [CFG_W-1:0] RST_BIT_SHORT  = 10'd10;
    localparam logic [CFG_W-1:0] RST_BIT_LONG   = 10'd30;
    localparam logic [CFG_W-1:0] RST_END_LOW    = 10'd15;
    localparam logic [CFG_W-1:0] RST_END_HOLD   = 10'd350;

    // Level handling.
    localparam logic [LEVEL_W-1:0] LEVEL_MIN  = 16'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 16'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 16'd32;
    localparam logic [7:0]         BYTE_BASE  = 8'd64;
    localparam logic [7:0]         BRIGHT_MIN = 8'd32;

    // Fixed segment lengths.
    localparam logic [DUR_W-1:0] OFF_LOW_US   = 16'd30000;
    localparam logic [DUR_W-1:0] HOLD_HIGH_US = 16'd10000;

    // Display command writes.
    localparam logic [7:0] DCS_PAGE_CMD  = 8'hFF;
    localparam logic [7:0] DCS_PAGE_PAR  = 8'h00;
    localparam logic [7:0] DCS_RELOAD_CMD = 8'hFB;
    localparam logic [7:0] DCS_RELOAD_PAR = 8'h01;
    localparam logic [7:0] DCS_BRIGHT_CMD = 8'h51;

    // Result kinds.
    localparam logic KIND_PIN = 1'b0;
    localparam logic KIND_DCS = 1'b1;

    // Job modes handed from front to back.
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_HOLD = 2'd1;
    localparam logic [1:0] MODE_BYTE = 2'd2;

    // Sequencer step counts.
    localparam logic [4:0] BYTE_SEGS = 5'd19;
    localparam logic [4:0] ONE_SEG   = 5'd1;
    localparam logic [4:0] STEP_MAX  = 5'd21;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_val;
        logic [7:0] bright;
    } t_job;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

endpackage

`default_nettype wire

[sv/swbd_ifs.sv]
`default_nettype none

// Level request channel.
interface swbd_in_if;
    logic                          valid;
    logic                          ready;
    logic [swbd_pkg::LEVEL_W-1:0]  level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

// Result channel: pin segments and display command writes.
interface swbd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        item_kind;
    logic                        pin_level;
    logic [swbd_pkg::DUR_W-1:0]  duration_us;
    logic [7:0]                  dcs_command;
    logic [7:0]                  dcs_parameter;
    logic                        last;

    modport source (output valid, output item_kind, output pin_level, output duration_us,
                    output dcs_command, output dcs_parameter, output last, input ready);
    modport sink   (input valid, input item_kind, input pin_level, input duration_us,
                    input dcs_command, input dcs_parameter, input last, output ready);
endinterface

`default_nettype wire

[sv/single_wire_backlight_dimmer_top.sv]
// Flow: a level request is written into the job queue, and the back end loads the
// job's first result from the queue head into the output register when it is idle,
// then one result per cycle while the output is not stalled. A byte transfer yields 22
// results, an off or hold update 4, and a repeated level none; the back end sequencer emits them.
// Requests are taken back to back while the job queue has room.
// Reset (synchronous, active low) empties the queue and output, and restores defaults.
`default_nettype none

module single_wire_backlight_dimmer_top #(
    parameter int QUEUE_DEPTH = swbd_pkg::QUEUE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [swbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [swbd_pkg::CFG_W-1:0]       i_cfg_data,
    swbd_in_if.sink                               i_level_ch,
    swbd_out_if.source                            o_result_ch
);

    swbd_pkg::t_job    front_job;
    swbd_pkg::t_job    head_job;
    swbd_pkg::t_cfg_wr cfg_wr;
    logic              push;
    logic              pop;
    logic              empty;
    logic              full;

    assign cfg_wr.we    = i_cfg_we;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // Front end: filter and classify requests.
    swbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_in         (i_level_ch),
        .i_queue_full (full),
        .o_push       (push),
        .o_job        (front_job)
    );

    // Job queue between front and back.
    swbd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_empty (empty),
        .o_full  (full)
    );

    // Back end: emit pin segments and command writes.
    swbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_job       (head_job),
        .i_job_avail (!empty),
        .o_pop       (pop),
        .m_out       (o_result_ch)
    );

endmodule

`default_nettype wire

[sv/swbd_fifo.sv]
`default_nettype none

module swbd_fifo #(
    parameter int DEPTH = swbd_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire swbd_pkg::t_job i_data,
    input  wire logic          i_pop,
    output swbd_pkg::t_job     o_data,
    output logic               o_empty,
    output logic               o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    swbd_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    // No push into a full queue unless a pop frees a slot.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && i_push) |-> i_pop)
        else $error("queue overflow");

endmodule

`default_nettype wire

[sv/swbd_front.sv]
`default_nettype none

module swbd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    swbd_in_if.sink            s_in,
    input  wire logic          i_queue_full,
    output logic               o_push,
    output swbd_pkg::t_job     o_job
);

    logic [swbd_pkg::LEVEL_W-1:0] r_last_req;
    logic                         r_prev_zero;
    logic                         r_prev_high;
    logic                         accept;
    logic                         changed;
    logic                         req_zero;
    logic [swbd_pkg::LEVEL_W-1:0] sat;
    logic [7:0]                   lvl8;
    logic                         lvl_high;

    assign s_in.ready = !i_queue_full;
    assign accept     = s_in.valid && s_in.ready;
    assign changed    = (s_in.level != r_last_req);
    assign req_zero   = (s_in.level == '0);
    assign o_push     = accept && changed && !(req_zero && r_prev_zero);

    // Saturate the level into 3..255.
    always_comb begin
        priority if (s_in.level <= swbd_pkg::LEVEL_MIN) begin
            sat = swbd_pkg::LEVEL_MIN;
        end else if (s_in.level > swbd_pkg::LEVEL_MAX) begin
            sat = swbd_pkg::LEVEL_MAX;
        end else begin
            sat = s_in.level;
        end
    end

    assign lvl8     = sat[7:0];
    assign lvl_high = (sat >= swbd_pkg::LEVEL_HIGH);

    // Classify the request into a job for the back end.
    always_comb begin
        o_job.byte_val = '0;
        o_job.bright   = lvl_high ? lvl8 : swbd_pkg::BRIGHT_MIN;
        priority if (req_zero) begin
            o_job.mode = swbd_pkg::MODE_OFF;
        end else if (!lvl_high) begin
            o_job.mode     = swbd_pkg::MODE_BYTE;
            o_job.byte_val = swbd_pkg::BYTE_BASE - {lvl8[6:0], 1'b0};
        end else if (r_prev_high) begin
            o_job.mode = swbd_pkg::MODE_HOLD;
        end else begin
            o_job.mode = swbd_pkg::MODE_BYTE;
        end
    end

    // Request history: last request and flags of the last sent level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_req  <= '0;
            r_prev_zero <= 1'b1;
            r_prev_high <= 1'b0;
        end else begin
            if (accept && changed) begin
                r_last_req <= s_in.level;
            end
            if (o_push) begin
                r_prev_zero <= req_zero;
                r_prev_high <= (s_in.level >= swbd_pkg::LEVEL_HIGH);
            end
        end
    end

    // A repeated request never creates a job.
    a_repeat_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_in.level == r_last_req)) |-> !o_push)
        else $error("repeated level produced a job");

endmodule

`default_nettype wire

[sv/swbd_back.sv]
`default_nettype none

module swbd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire swbd_pkg::t_cfg_wr i_cfg,
    input  wire swbd_pkg::t_job    i_job,
    input  wire logic              i_job_avail,
    output logic                   o_pop,
    swbd_out_if.source             m_out
);

    logic [swbd_pkg::CFG_W-1:0] r_start_high, r_bit_short, r_bit_long, r_end_low, r_end_hold;

    logic [4:0] r_step, n_step;
    logic [4:0] nseg;
    logic       advance;
    logic       is_last;
    logic [3:0] k;
    logic       data_bit;
    logic [1:0] dcs_idx;
    logic [4:0] dcs_off;

    // Next result.
    logic                         n_kind;
    logic                         n_pin;
    logic [swbd_pkg::DUR_W-1:0]   n_dur;
    logic [7:0]                   n_cmd;
    logic [7:0]                   n_par;

    logic                         r_valid;
    logic                         r_kind;
    logic                         r_pin;
    logic [swbd_pkg::DUR_W-1:0]   r_dur;
    logic [7:0]                   r_cmd;
    logic [7:0]                   r_par;
    logic                         r_last;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_high <= swbd_pkg::RST_START_HIGH;
            r_bit_short  <= swbd_pkg::RST_BIT_SHORT;
            r_bit_long   <= swbd_pkg::RST_BIT_LONG;
            r_end_low    <= swbd_pkg::RST_END_LOW;
            r_end_hold   <= swbd_pkg::RST_END_HOLD;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                swbd_pkg::CFG_START_HIGH: r_start_high <= i_cfg.data;
                swbd_pkg::CFG_BIT_SHORT:  r_bit_short  <= i_cfg.data;
                swbd_pkg::CFG_BIT_LONG:   r_bit_long   <= i_cfg.data;
                swbd_pkg::CFG_END_LOW:    r_end_low    <= i_cfg.data;
                swbd_pkg::CFG_END_HOLD:   r_end_hold   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Step bookkeeping: pin segments come first, then three command writes.
    assign nseg     = (i_job.mode == swbd_pkg::MODE_BYTE) ? swbd_pkg::BYTE_SEGS
                                                          : swbd_pkg::ONE_SEG;
    assign advance  = i_job_avail && (!r_valid || m_out.ready);
    assign is_last  = (r_step == nseg + 5'd2);
    assign o_pop    = advance && is_last;
    assign n_step   = is_last ? '0 : r_step + 1'b1;
    assign k        = 4'(r_step - 5'd1);
    assign data_bit = i_job.byte_val[~k[3:1]];
    assign dcs_off  = r_step - nseg;
    assign dcs_idx  = dcs_off[1:0];

    // Build the result for the current step.
    always_comb begin
        n_kind = swbd_pkg::KIND_PIN;
        n_pin  = 1'b0;
        n_dur  = '0;
        n_cmd  = '0;
        n_par  = '0;
        if (r_step >= nseg) begin
            n_kind = swbd_pkg::KIND_DCS;
            unique case (dcs_idx)
                2'd0: begin
                    n_cmd = swbd_pkg::DCS_PAGE_CMD;
                    n_par = swbd_pkg::DCS_PAGE_PAR;
                end
                2'd1: begin
                    n_cmd = swbd_pkg::DCS_RELOAD_CMD;
                    n_par = swbd_pkg::DCS_RELOAD_PAR;
                end
                default: begin
                    n_cmd = swbd_pkg::DCS_BRIGHT_CMD;
                    n_par = i_job.bright;
                end
            endcase
        end else if (i_job.mode == swbd_pkg::MODE_OFF) begin
            n_pin = 1'b0;
            n_dur = swbd_pkg::OFF_LOW_US;
        end else if (i_job.mode == swbd_pkg::MODE_HOLD) begin
            n_pin = 1'b1;
            n_dur = swbd_pkg::HOLD_HIGH_US;
        end else if (r_step == 5'd0) begin
            n_pin = 1'b1;
            n_dur = swbd_pkg::DUR_W'(r_start_high);
        end else if (r_step == 5'd17) begin
            n_pin = 1'b0;
            n_dur = swbd_pkg::DUR_W'(r_end_low);
        end else if (r_step == 5'd18) begin
            n_pin = 1'b1;
            n_dur = swbd_pkg::DUR_W'(r_end_hold);
        end else begin
            // A data bit: the long phase falls where the pin equals the bit.
            n_pin = k[0];
            n_dur = (data_bit == k[0]) ? swbd_pkg::DUR_W'(r_bit_long)
                                       : swbd_pkg::DUR_W'(r_bit_short);
        end
    end

    // Step counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step  <= n_step;
                r_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind <= n_kind;
            r_pin  <= n_pin;
            r_dur  <= n_dur;
            r_cmd  <= n_cmd;
            r_par  <= n_par;
            r_last <= is_last;
        end
    end

    assign m_out.valid         = r_valid;
    assign m_out.item_kind     = r_kind;
    assign m_out.pin_level     = r_pin;
    assign m_out.duration_us   = r_dur;
    assign m_out.dcs_command   = r_cmd;
    assign m_out.dcs_parameter = r_par;
    assign m_out.last          = r_last;

    // The step never runs past the longest job.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= swbd_pkg::STEP_MAX)
        else $error("sequencer step out of range");

    // The final transaction of a job is always the brightness write.
    a_last_is_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_kind == swbd_pkg::KIND_DCS
                                 && r_cmd == swbd_pkg::DCS_BRIGHT_CMD))
        else $error("last transaction is not the brightness write");

    // A job leaves the queue only from its final step.
    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_step == 5'd0 && r_last))
        else $error("job popped before its final step");

endmodule

`default_nettype wire

[verif/single_wire_backlight_dimmer_top_tb.sv]
`timescale 1ns / 100ps

module single_wire_backlight_dimmer_top_tb;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 250;

    // One result as the block should present it.
    typedef struct {
        logic                       kind;
        logic                       pin;
        logic [swbd_pkg::DUR_W-1:0] dur;
        logic [7:0]                 cmd;
        logic [7:0]                 par;
        logic                       last;
    } t_dimmer_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                           cfg_we;
    logic [swbd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [swbd_pkg::CFG_W-1:0]     cfg_data;

    swbd_in_if  level_ch ();
    swbd_out_if result_ch ();

    single_wire_backlight_dimmer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_level_ch  (level_ch),
        .o_result_ch (result_ch)
    );

    // Shadow copy of the timing registers and the dimmer state.
    logic [swbd_pkg::CFG_W-1:0]   start_high, bit_short, bit_long, end_low, end_hold;
    logic [swbd_pkg::LEVEL_W-1:0] last_request, last_sent;

    logic [swbd_pkg::LEVEL_W-1:0] pending_levels [$];
    t_dimmer_result               due_outputs [$];
    logic [swbd_pkg::LEVEL_W-1:0] gen_last;

    int  levels_queued   = 0;
    int  levels_accepted = 0;
    int  updates_seen    = 0;
    int  results_seen    = 0;
    int  reg_writes      = 0;
    int  mismatches      = 0;
    int  cycle_count     = 0;
    int  send_gap        = 0;
    int  stall_left      = 0;
    int  hold_left       = 0;
    bit  hold_request    = 1'b0;
    bit  level_taken     = 1'b0;
    bit  steady_mode     = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Reporting and checking helpers.
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [swbd_pkg::DUR_W-1:0] got,
                               input logic [swbd_pkg::DUR_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      results_seen, name, got, want));
        end
    endtask

    // Expected-result builders.
    task automatic push_pin(input logic pin, input logic [swbd_pkg::DUR_W-1:0] dur);
        due_outputs.push_back('{swbd_pkg::KIND_PIN, pin, dur, 8'h00, 8'h00, 1'b0});
    endtask

    task automatic push_cmd(input logic [7:0] cmd, input logic [7:0] par, input logic last);
        due_outputs.push_back('{swbd_pkg::KIND_DCS, 1'b0, '0, cmd, par, last});
    endtask

    // A byte goes out MSB first, each bit as a low phase followed by a high phase.
    task automatic push_byte_transfer(input logic [7:0] value);
        push_pin(1'b1, swbd_pkg::DUR_W'(start_high));
        for (int i = 7; i >= 0; i--) begin
            if (value[i]) begin
                push_pin(1'b0, swbd_pkg::DUR_W'(bit_short));
                push_pin(1'b1, swbd_pkg::DUR_W'(bit_long));
            end else begin
                push_pin(1'b0, swbd_pkg::DUR_W'(bit_long));
                push_pin(1'b1, swbd_pkg::DUR_W'(bit_short));
            end
        end
        push_pin(1'b0, swbd_pkg::DUR_W'(end_low));
        push_pin(1'b1, swbd_pkg::DUR_W'(end_hold));
    endtask

    // Works out the pin segments and command writes that one level request causes.
    task automatic predict_dimming(input logic [swbd_pkg::LEVEL_W-1:0] req);
        logic [swbd_pkg::LEVEL_W-1:0] lvl;
        logic [7:0]                   bright;
        if (req == last_request) begin
            return;
        end
        last_request = req;
        if (req == '0 && last_sent == '0) begin
            return;
        end
        updates_seen++;
        lvl = req;
        if (req != '0) begin
            if (lvl <= swbd_pkg::LEVEL_MIN) begin
                lvl = swbd_pkg::LEVEL_MIN;
            end else if (lvl > swbd_pkg::LEVEL_MAX) begin
                lvl = swbd_pkg::LEVEL_MAX;
            end
            if (lvl < swbd_pkg::LEVEL_HIGH) begin
                push_byte_transfer(swbd_pkg::BYTE_BASE - {lvl[6:0], 1'b0});
            end else if (last_sent >= swbd_pkg::LEVEL_HIGH) begin
                push_pin(1'b1, swbd_pkg::HOLD_HIGH_US);
            end else begin
                push_byte_transfer(8'd0);
            end
        end else begin
            push_pin(1'b0, swbd_pkg::OFF_LOW_US);
        end
        bright = (lvl < swbd_pkg::LEVEL_HIGH) ? swbd_pkg::BRIGHT_MIN : lvl[7:0];
        push_cmd(swbd_pkg::DCS_PAGE_CMD, swbd_pkg::DCS_PAGE_PAR, 1'b0);
        push_cmd(swbd_pkg::DCS_RELOAD_CMD, swbd_pkg::DCS_RELOAD_PAR, 1'b0);
        push_cmd(swbd_pkg::DCS_BRIGHT_CMD, bright, 1'b1);
        last_sent = req;
    endtask

    // Stimulus helpers.
    task automatic queue_level(input logic [swbd_pkg::LEVEL_W-1:0] lvl);
        pending_levels.push_back(lvl);
        levels_queued++;
        gen_last = lvl;
    endtask

    // Queues random requests until the given number of non-repeated levels is reached.
    task automatic queue_random(input int updates);
        int                           made;
        int unsigned                  pick;
        logic [swbd_pkg::LEVEL_W-1:0] lvl;
        made = 0;
        while (made < updates) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                lvl = gen_last;
            end else if (pick < 20) begin
                lvl = '0;
            end else if (pick < 60) begin
                lvl = swbd_pkg::LEVEL_W'($urandom_range(1, 40));
            end else if (pick < 85) begin
                lvl = swbd_pkg::LEVEL_W'($urandom_range(41, 300));
            end else begin
                lvl = swbd_pkg::LEVEL_W'($urandom_range(0, 65535));
            end
            if (lvl != gen_last) begin
                made++;
            end
            queue_level(lvl);
        end
    endtask

    task automatic write_reg(input logic [swbd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swbd_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        reg_writes++;
        unique case (idx)
            swbd_pkg::CFG_START_HIGH: start_high = val;
            swbd_pkg::CFG_BIT_SHORT:  bit_short  = val;
            swbd_pkg::CFG_BIT_LONG:   bit_long   = val;
            swbd_pkg::CFG_END_LOW:    end_low    = val;
            swbd_pkg::CFG_END_HOLD:   end_hold   = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [swbd_pkg::CFG_W-1:0] sh,
                              input logic [swbd_pkg::CFG_W-1:0] bs,
                              input logic [swbd_pkg::CFG_W-1:0] bl,
                              input logic [swbd_pkg::CFG_W-1:0] el,
                              input logic [swbd_pkg::CFG_W-1:0] eh);
        write_reg(swbd_pkg::CFG_START_HIGH, sh);
        write_reg(swbd_pkg::CFG_BIT_SHORT, bs);
        write_reg(swbd_pkg::CFG_BIT_LONG, bl);
        write_reg(swbd_pkg::CFG_END_LOW, el);
        write_reg(swbd_pkg::CFG_END_HOLD, eh);
    endtask

    // Waits until every request is taken and every result has come, then lets the
    // block finish any request that causes nothing.
    task automatic wait_quiet();
        while (!(levels_accepted == levels_queued && due_outputs.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: holds an offered level until its transaction completes.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            level_ch.valid <= 1'b0;
        end else if (level_ch.valid && !level_taken) begin
            // Keep offering the same level.
        end else begin
            level_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                level_ch.valid <= 1'b0;
            end else if (pending_levels.size() > 0) begin
                level_ch.valid <= 1'b1;
                level_ch.level <= pending_levels.pop_front();
                if (!steady_mode && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 3);
                end
            end else begin
                level_ch.valid <= 1'b0;
            end
        end
    end

    // Request monitor: every accepted level updates the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && level_ch.valid && level_ch.ready) begin
            predict_dimming(level_ch.level);
            levels_accepted++;
            level_taken = 1'b1;
        end
    end

    // Result receiver: short random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
            if (!steady_mode && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
        end
    end

    // Result monitor: each transaction is checked against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_dimmer_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (due_outputs.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                want = due_outputs.pop_front();
                check_field("item_kind", swbd_pkg::DUR_W'(result_ch.item_kind),
                            swbd_pkg::DUR_W'(want.kind));
                check_field("pin_level", swbd_pkg::DUR_W'(result_ch.pin_level),
                            swbd_pkg::DUR_W'(want.pin));
                check_field("duration_us", result_ch.duration_us, want.dur);
                check_field("dcs_command", swbd_pkg::DUR_W'(result_ch.dcs_command),
                            swbd_pkg::DUR_W'(want.cmd));
                check_field("dcs_parameter", swbd_pkg::DUR_W'(result_ch.dcs_parameter),
                            swbd_pkg::DUR_W'(want.par));
                check_field("last", swbd_pkg::DUR_W'(result_ch.last),
                            swbd_pkg::DUR_W'(want.last));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results still expected.",
                     cycle_count, due_outputs.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        logic [swbd_pkg::LEVEL_W-1:0] directed [$];
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        level_ch.valid  = 1'b0;
        level_ch.level  = '0;
        result_ch.ready = 1'b0;
        start_high      = swbd_pkg::RST_START_HIGH;
        bit_short       = swbd_pkg::RST_BIT_SHORT;
        bit_long        = swbd_pkg::RST_BIT_LONG;
        end_low         = swbd_pkg::RST_END_LOW;
        end_hold        = swbd_pkg::RST_END_HOLD;
        last_request    = '0;
        last_sent       = '0;
        gen_last        = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: repeats, the clamp at three, the threshold at 32, saturation,
        // the hold after a high level, and the off segment.
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd31, 16'd32, 16'd33,
                     16'd255, 16'd256, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd40,
                     16'hAAAA, 16'h5555, 16'd0, 16'd31, 16'd100, 16'h8000, 16'd1,
                     16'd0};
        foreach (directed[i]) begin
            queue_level(directed[i]);
        end
        wait_quiet();

        // Longest timings, and writes to indexes past the last register.
        set_timing('1, '1, '1, '1, '1);
        for (int k = int'(swbd_pkg::CFG_END_HOLD) + 1; k < (1 << swbd_pkg::CFG_IDX_W);
             k++) begin
            write_reg(swbd_pkg::CFG_IDX_W'(k), swbd_pkg::CFG_W'($urandom_range(0, 1023)));
        end
        queue_random(40);
        wait_quiet();

        // Zero-length segments.
        set_timing('0, '0, '0, '0, '0);
        queue_random(30);
        wait_quiet();

        set_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
        queue_random(30);
        wait_quiet();

        repeat (3) begin
            set_timing(swbd_pkg::CFG_W'($urandom_range(0, 1023)),
                       swbd_pkg::CFG_W'($urandom_range(0, 1023)),
                       swbd_pkg::CFG_W'($urandom_range(0, 1023)),
                       swbd_pkg::CFG_W'($urandom_range(0, 1023)),
                       swbd_pkg::CFG_W'($urandom_range(0, 1023)));
            queue_random(40);
            wait_quiet();
        end

        // Receiver holds off long enough for the job queue to fill and stall requests.
        hold_request = 1'b1;
        queue_random(25);
        wait_quiet();

        // Closing stretch with defaults and no idling on either side.
        set_timing(swbd_pkg::RST_START_HIGH, swbd_pkg::RST_BIT_SHORT, swbd_pkg::RST_BIT_LONG,
                   swbd_pkg::RST_END_LOW, swbd_pkg::RST_END_HOLD);
        steady_mode = 1'b1;
        queue_random(50);
        wait_quiet();

        $display("Run covered %0d level requests, %0d of them updates, and %0d results.",
                 levels_accepted, updates_seen, results_seen);
        $display("Timing: defaults, all max, all zero, all one, random; %0d register writes.",
                 reg_writes);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
sv/swbd_pkg.sv
sv/swbd_ifs.sv
sv/swbd_fifo.sv
sv/swbd_front.sv
sv/swbd_back.sv
sv/single_wire_backlight_dimmer_top.sv
verif/single_wire_backlight_dimmer_top_tb.sv
